### hdl/closest_farthest_point_pair_assert.svh
// Assertion macros for the closest and farthest point pair RTL.
`ifndef CLOSEST_FARTHEST_POINT_PAIR_ASSERT_SVH
`define CLOSEST_FARTHEST_POINT_PAIR_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CFPP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CFPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/cfpp_pkg.sv
// Package with the sizes and types of the closest and farthest point pair block.
package cfpp_pkg;

   localparam int MAX_POINTS = 16;
   localparam int COORD_BITS = 8;
   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int DIST_BITS  = 2 * COORD_BITS + 2;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
   } point_type;

   typedef struct packed {
      logic                valid;
      logic [IDX_BITS-1:0] first;
      logic [IDX_BITS-1:0] second;
   } pair_tag_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]  first;
      logic [IDX_BITS-1:0]  second;
      logic [DIST_BITS-1:0] dist_sq;
   } pair_best_type;

endpackage

### hdl/cfpp_point_store.sv
// Point memory with one write port and two registered read ports.
module cfpp_point_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [cfpp_pkg::IDX_BITS-1:0] wr_addr,
   input  cfpp_pkg::point_type           wr_point,
   input  logic [cfpp_pkg::IDX_BITS-1:0] rd_addr_a,
   input  logic [cfpp_pkg::IDX_BITS-1:0] rd_addr_b,
   output cfpp_pkg::point_type           rd_point_a,
   output cfpp_pkg::point_type           rd_point_b
);
   import cfpp_pkg::*;

   point_type mem_ff [MAX_POINTS];
   point_type rd_a_ff;
   point_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_point;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_point_a = rd_a_ff;
   assign rd_point_b = rd_b_ff;

endmodule

### hdl/cfpp_dist_unit.sv
// Shared two-stage unit that computes the squared distance of one point pair.
module cfpp_dist_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  cfpp_pkg::point_type            point_a,
   input  cfpp_pkg::point_type            point_b,
   input  cfpp_pkg::pair_tag_type         tag_in,
   output logic [cfpp_pkg::DIST_BITS-1:0] dist_sq,
   output cfpp_pkg::pair_tag_type         tag_out,
   output logic                           pending
);
   import cfpp_pkg::*;

   function automatic logic [SQ_BITS-1:0] square_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      logic signed [COORD_BITS:0]     diff;
      logic signed [2*COORD_BITS+1:0] prod;
      diff = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
      prod = diff * diff;
      return prod[SQ_BITS-1:0];
   endfunction

   logic [SQ_BITS-1:0]   sq_x_ff;
   logic [SQ_BITS-1:0]   sq_y_ff;
   logic [SQ_BITS-1:0]   sq_z_ff;
   logic [DIST_BITS-1:0] sum_ff;
   logic [DIST_BITS-1:0] sum_in;
   pair_tag_type         tag_s2_ff;
   pair_tag_type         tag_s3_ff;

   assign sum_in = DIST_BITS'(sq_x_ff) + DIST_BITS'(sq_y_ff) + DIST_BITS'(sq_z_ff);

   always_ff @(posedge clock) begin
      sq_x_ff <= square_diff(point_a.x, point_b.x);
      sq_y_ff <= square_diff(point_a.y, point_b.y);
      sq_z_ff <= square_diff(point_a.z, point_b.z);
      sum_ff  <= sum_in;
      if (reset) begin
         tag_s2_ff.valid <= 1'b0;
         tag_s3_ff.valid <= 1'b0;
      end else begin
         tag_s2_ff <= tag_in;
         tag_s3_ff <= tag_s2_ff;
      end
   end

   assign dist_sq = sum_ff;
   assign tag_out = tag_s3_ff;
   assign pending = tag_s2_ff.valid | tag_s3_ff.valid;

endmodule

### hdl/cfpp_pair_track.sv
// Tracker that keeps the closest and farthest pair seen so far.
module cfpp_pair_track (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic [cfpp_pkg::DIST_BITS-1:0] dist_sq,
   input  cfpp_pkg::pair_tag_type         tag,
   output cfpp_pkg::pair_best_type        near_best,
   output cfpp_pkg::pair_best_type        far_best
);
   import cfpp_pkg::*;

   logic          have_ff;
   pair_best_type near_ff;
   pair_best_type far_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         have_ff <= 1'b0;
         near_ff <= '0;
         far_ff  <= '0;
      end else if (tag.valid) begin
         // A tie keeps the pair that was found first.
         if (!have_ff || (dist_sq < near_ff.dist_sq)) begin
            near_ff <= '{tag.first, tag.second, dist_sq};
         end
         if (!have_ff || (dist_sq > far_ff.dist_sq)) begin
            far_ff <= '{tag.first, tag.second, dist_sq};
         end
         have_ff <= 1'b1;
      end
   end

   assign near_best = near_ff;
   assign far_best  = far_ff;

endmodule

### hdl/closest_farthest_point_pair.sv
// Top level of the closest and farthest point pair search.
//
// Each request loads one 3-D point into a 16-entry store when start is high
// and busy is low. Ordinary points are taken one per cycle and busy stays low.
// A request with req_last_point set ends the set: busy rises and a sequencer
// walks every pair (i<j) in load order, one pair per cycle, through the
// shared squared-distance unit and the best-pair tracker.
// The result follows once every pair has passed the registered store read, the
// distance unit and the tracker; when fewer than two points are held, no pair
// is walked.
// The result is shown for exactly one cycle with rsp_strobe high, and busy is
// already low in that cycle. The receiver cannot stall the result.
// Points that arrive while the store is full are discarded and rsp_dropped is
// set in the result of that set; a discarded last point still starts the
// search. Reset empties the set and returns the block to loading.
module closest_farthest_point_pair (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [cfpp_pkg::COORD_BITS-1:0] req_coord_x,
   input  logic signed [cfpp_pkg::COORD_BITS-1:0] req_coord_y,
   input  logic signed [cfpp_pkg::COORD_BITS-1:0] req_coord_z,
   input  logic                                   req_last_point,
   output logic                                   rsp_strobe,
   output logic [cfpp_pkg::IDX_BITS-1:0]          rsp_near_first,
   output logic [cfpp_pkg::IDX_BITS-1:0]          rsp_near_second,
   output logic [cfpp_pkg::DIST_BITS-1:0]         rsp_near_dist_sq,
   output logic [cfpp_pkg::IDX_BITS-1:0]          rsp_far_first,
   output logic [cfpp_pkg::IDX_BITS-1:0]          rsp_far_second,
   output logic [cfpp_pkg::DIST_BITS-1:0]         rsp_far_dist_sq,
   output logic [cfpp_pkg::CNT_BITS-1:0]          rsp_points_held,
   output logic                                   rsp_too_few,
   output logic                                   rsp_dropped
);
   import cfpp_pkg::*;

   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;

   logic [1:0]           state_ff;
   logic [CNT_BITS-1:0]  count_ff;
   logic                 overflow_ff;
   logic [CNT_BITS-1:0]  held_ff;
   logic [IDX_BITS-1:0]  last_idx_ff;
   logic                 set_dropped_ff;
   logic [IDX_BITS-1:0]  i_ff;
   logic [IDX_BITS-1:0]  j_ff;
   pair_tag_type         tag_s1_ff;

   logic                 rsp_strobe_ff;
   pair_best_type        rsp_near_ff;
   pair_best_type        rsp_far_ff;
   logic [CNT_BITS-1:0]  rsp_held_ff;
   logic                 rsp_too_few_ff;
   logic                 rsp_dropped_ff;

   logic                 accept;
   logic                 full;
   logic [CNT_BITS-1:0]  held_in;
   point_type            wr_point;
   pair_tag_type         issue_tag;
   point_type            point_a;
   point_type            point_b;
   logic [DIST_BITS-1:0] dist_sq;
   pair_tag_type         dist_tag;
   logic                 dist_pending;
   pair_best_type        near_best;
   pair_best_type        far_best;

   logic                 pair_rsp;
   logic                 pair_ok;
   logic                 short_rsp;
   logic                 short_zero;

   assign busy      = (state_ff != ST_LOAD);
   assign accept    = start && !busy;
   assign full      = (count_ff == CNT_BITS'(MAX_POINTS));
   assign held_in   = full ? count_ff : count_ff + CNT_BITS'(1);
   assign wr_point  = '{x: req_coord_x, y: req_coord_y, z: req_coord_z};
   assign issue_tag = '{valid: (state_ff == ST_SEARCH), first: i_ff, second: j_ff};

   cfpp_point_store u_store (
      .clock      (clock),
      .wr_en      (accept && !full),
      .wr_addr    (count_ff[IDX_BITS-1:0]),
      .wr_point   (wr_point),
      .rd_addr_a  (i_ff),
      .rd_addr_b  (j_ff),
      .rd_point_a (point_a),
      .rd_point_b (point_b)
   );

   cfpp_dist_unit u_dist (
      .clock   (clock),
      .reset   (reset),
      .point_a (point_a),
      .point_b (point_b),
      .tag_in  (tag_s1_ff),
      .dist_sq (dist_sq),
      .tag_out (dist_tag),
      .pending (dist_pending)
   );

   cfpp_pair_track u_track (
      .clock     (clock),
      .reset     (reset),
      .clear     (accept && req_last_point),
      .dist_sq   (dist_sq),
      .tag       (dist_tag),
      .near_best (near_best),
      .far_best  (far_best)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         count_ff        <= '0;
         overflow_ff     <= 1'b0;
         tag_s1_ff.valid <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         tag_s1_ff     <= issue_tag;
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (req_last_point) begin
                     held_ff        <= held_in;
                     last_idx_ff    <= IDX_BITS'(held_in - CNT_BITS'(1));
                     set_dropped_ff <= overflow_ff | full;
                     count_ff       <= '0;
                     overflow_ff    <= 1'b0;
                     i_ff           <= '0;
                     j_ff           <= IDX_BITS'(1);
                     state_ff       <= (held_in < CNT_BITS'(2)) ? ST_DRAIN : ST_SEARCH;
                  end else begin
                     count_ff    <= held_in;
                     overflow_ff <= overflow_ff | full;
                  end
               end
            end
            ST_SEARCH: begin
               if (j_ff == last_idx_ff) begin
                  if ((i_ff + IDX_BITS'(1)) == last_idx_ff) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     i_ff <= i_ff + IDX_BITS'(1);
                     j_ff <= i_ff + IDX_BITS'(2);
                  end
               end else begin
                  j_ff <= j_ff + IDX_BITS'(1);
               end
            end
            ST_DRAIN: begin
               if (!tag_s1_ff.valid && !dist_pending) begin
                  rsp_strobe_ff  <= 1'b1;
                  rsp_near_ff    <= near_best;
                  rsp_far_ff     <= far_best;
                  rsp_held_ff    <= held_ff;
                  rsp_too_few_ff <= (held_ff < CNT_BITS'(2));
                  rsp_dropped_ff <= set_dropped_ff;
                  state_ff       <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_near_first   = rsp_near_ff.first;
   assign rsp_near_second  = rsp_near_ff.second;
   assign rsp_near_dist_sq = rsp_near_ff.dist_sq;
   assign rsp_far_first    = rsp_far_ff.first;
   assign rsp_far_second   = rsp_far_ff.second;
   assign rsp_far_dist_sq  = rsp_far_ff.dist_sq;
   assign rsp_points_held  = rsp_held_ff;
   assign rsp_too_few      = rsp_too_few_ff;
   assign rsp_dropped      = rsp_dropped_ff;

   assign pair_rsp   = rsp_strobe && !rsp_too_few;
   assign pair_ok    = (rsp_near_dist_sq <= rsp_far_dist_sq) &&
                       (rsp_near_first < rsp_near_second);
   assign short_rsp  = rsp_strobe && rsp_too_few;
   assign short_zero = (rsp_near_dist_sq == '0) && (rsp_far_dist_sq == '0);

`include "closest_farthest_point_pair_assert.svh"

   `CFPP_ASSERT_SAME(a_rsp_while_idle, clock, reset, rsp_strobe, !busy, "Result shown while busy.")
   `CFPP_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe, "Result strobe repeated.")
   `CFPP_ASSERT_SAME(a_near_not_far, clock, reset, pair_rsp, pair_ok, "Closest pair is wrong.")
   `CFPP_ASSERT_SAME(a_too_few_zero, clock, reset, short_rsp, short_zero, "Short set has pairs.")

endmodule

### sim/tb_closest_farthest_point_pair.sv
// Self-checking testbench for the closest and farthest point pair search.
module tb_closest_farthest_point_pair;
   timeunit 1ns;
   timeprecision 1ps;

   import cfpp_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int ITEMS_PER_PHASE = 110;
   localparam int SETTLE_CYCLES   = MAX_POINTS * (MAX_POINTS - 1) / 2 + 8;
   localparam int WATCHDOG_LIMIT  = 2000;

   typedef struct {
      logic [IDX_BITS-1:0]  near_first;
      logic [IDX_BITS-1:0]  near_second;
      logic [DIST_BITS-1:0] near_dist_sq;
      logic [IDX_BITS-1:0]  far_first;
      logic [IDX_BITS-1:0]  far_second;
      logic [DIST_BITS-1:0] far_dist_sq;
      logic [CNT_BITS-1:0]  points_held;
      logic                 too_few;
      logic                 dropped;
   } pair_report_type;

   typedef struct {
      point_type       pt;
      logic            last;
      int              copies;
      logic            typed;
      pair_report_type want;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [COORD_BITS-1:0] req_coord_x;
   logic signed [COORD_BITS-1:0] req_coord_y;
   logic signed [COORD_BITS-1:0] req_coord_z;
   logic                         req_last_point;
   logic                         rsp_strobe;
   logic [IDX_BITS-1:0]          rsp_near_first;
   logic [IDX_BITS-1:0]          rsp_near_second;
   logic [DIST_BITS-1:0]         rsp_near_dist_sq;
   logic [IDX_BITS-1:0]          rsp_far_first;
   logic [IDX_BITS-1:0]          rsp_far_second;
   logic [DIST_BITS-1:0]         rsp_far_dist_sq;
   logic [CNT_BITS-1:0]          rsp_points_held;
   logic                         rsp_too_few;
   logic                         rsp_dropped;

   point_type       held_points [MAX_POINTS];
   int              held_count;
   logic            store_overflowed;
   pair_report_type pending_reports [$];
   stim_row_type    stim_rows [$];
   int              mismatches = 0;
   int              quiet_cycles = 0;

   closest_farthest_point_pair i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .req_last_point   (req_last_point),
      .rsp_strobe       (rsp_strobe),
      .rsp_near_first   (rsp_near_first),
      .rsp_near_second  (rsp_near_second),
      .rsp_near_dist_sq (rsp_near_dist_sq),
      .rsp_far_first    (rsp_far_first),
      .rsp_far_second   (rsp_far_second),
      .rsp_far_dist_sq  (rsp_far_dist_sq),
      .rsp_points_held  (rsp_points_held),
      .rsp_too_few      (rsp_too_few),
      .rsp_dropped      (rsp_dropped)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   function automatic pair_report_type make_report(input int nf, input int ns, input int nd,
                                                   input int ff, input int fs, input int fd,
                                                   input int held, input int few,
                                                   input int drop);
      pair_report_type r;
      r.near_first   = IDX_BITS'(nf);
      r.near_second  = IDX_BITS'(ns);
      r.near_dist_sq = DIST_BITS'(nd);
      r.far_first    = IDX_BITS'(ff);
      r.far_second   = IDX_BITS'(fs);
      r.far_dist_sq  = DIST_BITS'(fd);
      r.points_held  = CNT_BITS'(held);
      r.too_few      = 1'(few);
      r.dropped      = 1'(drop);
      return r;
   endfunction

   function automatic int squared_gap(input point_type a, input point_type b);
      int dx;
      int dy;
      int dz;
      dx = int'($signed(a.x)) - int'($signed(b.x));
      dy = int'($signed(a.y)) - int'($signed(b.y));
      dz = int'($signed(a.z)) - int'($signed(b.z));
      return dx * dx + dy * dy + dz * dz;
   endfunction

   // Loads one point and, on the last point of a set, searches all pairs in load order.
   task automatic predict_point(input point_type pt, input logic last, output logic fired,
                                output pair_report_type res);
      int   gap;
      int   near_best;
      int   far_best;
      logic have;
      res = '{default: '0};
      fired = 1'b0;
      if (held_count < MAX_POINTS) begin
         held_points[held_count] = pt;
         held_count++;
      end else begin
         store_overflowed = 1'b1;
      end
      if (!last) return;
      fired = 1'b1;
      have = 1'b0;
      near_best = 0;
      far_best = 0;
      for (int i = 0; i < held_count; i++) begin
         for (int j = i + 1; j < held_count; j++) begin
            gap = squared_gap(held_points[i], held_points[j]);
            if (!have || gap < near_best) begin
               near_best = gap;
               res.near_first = IDX_BITS'(i);
               res.near_second = IDX_BITS'(j);
            end
            if (!have || gap > far_best) begin
               far_best = gap;
               res.far_first = IDX_BITS'(i);
               res.far_second = IDX_BITS'(j);
            end
            have = 1'b1;
         end
      end
      res.near_dist_sq = DIST_BITS'(near_best);
      res.far_dist_sq = DIST_BITS'(far_best);
      res.points_held = CNT_BITS'(held_count);
      res.too_few = (held_count < 2);
      res.dropped = store_overflowed;
      held_count = 0;
      store_overflowed = 1'b0;
   endtask

   task automatic send_point(input point_type pt, input logic last, input int idle_pct,
                             input logic typed, input pair_report_type want);
      logic            fired;
      pair_report_type predicted;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start <= 1'b1;
      req_coord_x <= pt.x;
      req_coord_y <= pt.y;
      req_coord_z <= pt.z;
      req_last_point <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_point(pt, last, fired, predicted);
      if (fired) begin
         pending_reports.push_back(typed ? want : predicted);
      end
   endtask

   task automatic pause_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input int x, input int y, input int z, input logic last,
                          input int copies, input logic typed, input pair_report_type want);
      stim_row_type row;
      row.pt.x = COORD_BITS'(x);
      row.pt.y = COORD_BITS'(y);
      row.pt.z = COORD_BITS'(z);
      row.last = last;
      row.copies = copies;
      row.typed = typed;
      row.want = want;
      stim_rows.push_back(row);
   endtask

   always @(posedge clock) begin
      pair_report_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
         if (rsp_strobe) begin
            if (pending_reports.size() == 0) begin
               report_mismatch("result arrived with no point set pending");
            end else begin
               want = pending_reports.pop_front();
               check_field("near_first", 32'(rsp_near_first), 32'(want.near_first));
               check_field("near_second", 32'(rsp_near_second), 32'(want.near_second));
               check_field("near_dist_sq", 32'(rsp_near_dist_sq), 32'(want.near_dist_sq));
               check_field("far_first", 32'(rsp_far_first), 32'(want.far_first));
               check_field("far_second", 32'(rsp_far_second), 32'(want.far_second));
               check_field("far_dist_sq", 32'(rsp_far_dist_sq), 32'(want.far_dist_sq));
               check_field("points_held", 32'(rsp_points_held), 32'(want.points_held));
               check_field("too_few", 32'(rsp_too_few), 32'(want.too_few));
               check_field("dropped", 32'(rsp_dropped), 32'(want.dropped));
            end
         end
      end
   end

   initial begin
      pair_report_type blank_report;
      pair_report_type single_point;
      pair_report_type full_and_dropped;
      point_type       pt;
      int              idle_pct [4];
      int              items;
      int              set_size;
      int              pick;
      logic            clustered;

      reset <= 1'b1;
      start <= 1'b0;
      req_coord_x <= '0;
      req_coord_y <= '0;
      req_coord_z <= '0;
      req_last_point <= 1'b0;
      held_count = 0;
      store_overflowed = 1'b0;
      idle_pct = '{0, 47, 0, 21};
      blank_report = '{default: '0};
      single_point = make_report(0, 0, 0, 0, 0, 0, 1, 1, 0);
      full_and_dropped = make_report(0, 1, 0, 0, 1, 0, MAX_POINTS, 0, 1);

      add_row(0, 0, 0, 1'b1, 1, 1'b1, single_point);
      add_row(-128, -128, -128, 1'b0, 1, 1'b0, blank_report);
      add_row(127, 127, 127, 1'b1, 1, 1'b1,
              make_report(0, 1, 195075, 0, 1, 195075, 2, 0, 0));
      add_row(127, -128, 127, 1'b0, 1, 1'b0, blank_report);
      add_row(-128, 127, -128, 1'b0, 1, 1'b0, blank_report);
      add_row(5, -3, 77, 1'b1, 1, 1'b0, blank_report);
      add_row(0, 0, 0, 1'b0, 1, 1'b0, blank_report);
      add_row(1, 0, 0, 1'b0, 1, 1'b0, blank_report);
      add_row(0, 1, 0, 1'b1, 1, 1'b0, blank_report);
      add_row(-1, -1, -1, 1'b0, MAX_POINTS, 1'b0, blank_report);
      add_row(127, 127, 127, 1'b1, 1, 1'b1, full_and_dropped);
      add_row(3, 3, 3, 1'b0, MAX_POINTS, 1'b0, blank_report);
      add_row(-128, 0, 0, 1'b0, 2, 1'b0, blank_report);
      add_row(0, 0, -128, 1'b1, 1, 1'b1, full_and_dropped);
      add_row(10, -20, 30, 1'b0, MAX_POINTS - 1, 1'b0, blank_report);
      add_row(-128, 0, 127, 1'b1, 1, 1'b0, blank_report);
      add_row(-128, 127, -128, 1'b1, 1, 1'b1, single_point);
      add_row(-85, 42, -1, 1'b0, 1, 1'b0, blank_report);
      add_row(85, -43, 0, 1'b1, 1, 1'b0, blank_report);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r]) begin
         repeat (stim_rows[r].copies) begin
            send_point(stim_rows[r].pt, stim_rows[r].last, 0, stim_rows[r].typed,
                       stim_rows[r].want);
         end
      end

      for (int phase = 0; phase < 4; phase++) begin
         pause_for_results();
         items = 0;
         while (items < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
               set_size = $urandom_range(1, 5);
            end else if (pick < 18) begin
               set_size = $urandom_range(6, MAX_POINTS);
            end else begin
               set_size = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 3);
            end
            clustered = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < set_size; k++) begin
               if (clustered) begin
                  pt.x = COORD_BITS'($urandom_range(0, 6) - 3);
                  pt.y = COORD_BITS'($urandom_range(0, 6) - 3);
                  pt.z = COORD_BITS'($urandom_range(0, 6) - 3);
               end else begin
                  pt.x = COORD_BITS'($urandom);
                  pt.y = COORD_BITS'($urandom);
                  pt.z = COORD_BITS'($urandom);
               end
               send_point(pt, k == set_size - 1, idle_pct[phase], 1'b0, blank_report);
               items++;
            end
            if ($urandom_range(0, 9) == 0) pause_for_results();
         end
      end

      pause_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_reports.size()));
      end
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
